// File: design/ssmt_pkg.sv
// shared types and constants of the sorted set membership table
package ssmt_pkg;

    localparam int VALUE_W      = 64;
    localparam int COUNT_W      = 7;
    localparam int FUNC_W       = 2;
    localparam int IN_TDATA_W   = 64;
    localparam int OUT_TDATA_W  = 16;

    // operation codes carried in tuser
    typedef enum logic [FUNC_W-1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } func_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_REDUCE,
        ST_COMMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic reduce;
        logic commit;
    } ssmt_cmd_t;

endpackage

// File: design/ssmt_ctrl.sv
// controller state machine: handshakes and step sequencing
module ssmt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output ssmt_pkg::ssmt_cmd_t cmd
);

    ssmt_pkg::state_t state_reg;
    ssmt_pkg::state_t state_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             slot_free;

    assign slot_free = !m_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssmt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ssmt_pkg::ST_COMPARE;
                end
            end
            ssmt_pkg::ST_COMPARE: state_next = ssmt_pkg::ST_REDUCE;
            ssmt_pkg::ST_REDUCE:  state_next = ssmt_pkg::ST_COMMIT;
            ssmt_pkg::ST_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = ssmt_pkg::ST_IDLE;
                end
            end
            default: state_next = ssmt_pkg::ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb
    begin
        s_tready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ssmt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ssmt_pkg::ST_COMPARE: cmd.compare = 1'b1;
            ssmt_pkg::ST_REDUCE:  cmd.reduce  = 1'b1;
            ssmt_pkg::ST_COMMIT:  cmd.commit  = slot_free;
            default:              cmd         = '0;
        endcase
    end

    // output valid: set on commit, cleared when taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.commit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ssmt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: design/ssmt_datapath.sv
// datapath: row of compare cells, match reduction, ordered shift, result register
module ssmt_datapath
#(
    parameter int DEPTH = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssmt_pkg::ssmt_cmd_t            cmd,
    input  logic [ssmt_pkg::FUNC_W-1:0]    in_func,
    input  logic [ssmt_pkg::VALUE_W-1:0]   in_value,
    output logic                           was_member,
    output logic [ssmt_pkg::COUNT_W-1:0]   member_count,
    output logic                           add_dropped
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    ssmt_pkg::func_t                 func_reg;
    logic [ssmt_pkg::VALUE_W-1:0]    value_reg;
    logic [ssmt_pkg::VALUE_W-1:0]    entry_reg [DEPTH];
    logic [DEPTH-1:0]                lt_reg;
    logic [DEPTH-1:0]                eq_reg;
    logic                            present_reg;
    logic [CNT_W-1:0]                occ_reg;
    logic [CNT_W-1:0]                occ_next;
    logic                            full;
    logic                            do_add;
    logic                            do_remove;
    logic                            found;
    logic                            dropped;
    logic [CNT_W+ssmt_pkg::COUNT_W-1:0] cnt_ext;
    logic                            was_member_reg;
    logic [ssmt_pkg::COUNT_W-1:0]    count_reg;
    logic                            dropped_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= ssmt_pkg::func_t'(in_func);
            value_reg <= in_value;
        end
    end

    // per-cell compare against the held value, masked by occupancy
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cmp
            logic cell_valid;
            assign cell_valid = occ_reg > CNT_W'(gi);
            always_ff @(posedge clk)
            begin
                if (cmd.compare)
                begin
                    lt_reg[gi] <= cell_valid && (entry_reg[gi] < value_reg);
                    eq_reg[gi] <= cell_valid && (entry_reg[gi] == value_reg);
                end
            end
        end
    endgenerate

    // match reduction
    always_ff @(posedge clk)
    begin
        if (cmd.reduce)
        begin
            present_reg <= |eq_reg;
        end
    end

    // update decision
    assign full = occ_reg == CNT_W'(DEPTH);

    always_comb
    begin
        do_add    = 1'b0;
        do_remove = 1'b0;
        found     = present_reg;
        dropped   = 1'b0;
        occ_next  = occ_reg;
        unique case (func_reg)
            ssmt_pkg::OP_ADD:
            begin
                if (!present_reg)
                begin
                    if (full)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        do_add   = 1'b1;
                        occ_next = occ_reg + CNT_W'(1);
                    end
                end
            end
            ssmt_pkg::OP_REMOVE:
            begin
                if (present_reg)
                begin
                    do_remove = 1'b1;
                    occ_next  = occ_reg - CNT_W'(1);
                end
            end
            ssmt_pkg::OP_CONTAINS:
            begin
                occ_next = occ_reg;
            end
            ssmt_pkg::OP_CLEAR:
            begin
                found    = 1'b0;
                occ_next = '0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    // ordered shift: cells at or above the insert point move up, on remove down
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [ssmt_pkg::VALUE_W-1:0] from_below;
            logic [ssmt_pkg::VALUE_W-1:0] from_above;
            logic                         take_new;
            if (gi == 0)
            begin : g_first
                assign from_below = value_reg;
                assign take_new   = 1'b1;
            end
            else
            begin : g_rest
                assign from_below = entry_reg[gi-1];
                assign take_new   = lt_reg[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign from_above = entry_reg[gi];
            end
            else
            begin : g_inner
                assign from_above = entry_reg[gi+1];
            end
            always_ff @(posedge clk)
            begin
                if (cmd.commit && !lt_reg[gi])
                begin
                    if (do_add)
                    begin
                        entry_reg[gi] <= take_new ? value_reg : from_below;
                    end
                    else if (do_remove)
                    begin
                        entry_reg[gi] <= from_above;
                    end
                end
            end
        end
    endgenerate

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.commit)
        begin
            occ_reg <= occ_next;
        end
    end

    // result register
    assign cnt_ext = {{ssmt_pkg::COUNT_W{1'b0}}, occ_next};

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            was_member_reg <= found;
            count_reg      <= cnt_ext[ssmt_pkg::COUNT_W-1:0];
            dropped_reg    <= dropped;
        end
    end

    assign was_member   = was_member_reg;
    assign member_count = count_reg;
    assign add_dropped  = dropped_reg;

endmodule

// File: design/sorted_set_membership_table_core.sv
// top level of the sorted set membership table
//
// Holds up to DEPTH distinct 64-bit values in ascending order.
// Input channel s_*: one item per operation; s_tuser carries the operation
// (add, remove, contains, clear) and s_tdata the value.
// Output channel m_*: exactly one result item per input item, in order;
// m_tdata carries was_member, the member count after the operation and
// the add-dropped flag for an add of a new value that found the table full.
// Steps: an item is taken in the idle state, then the compare step checks it
// against every stored entry in parallel, the reduce step combines the match
// flags, and the commit step applies the ordered shift and loads the result
// register. A new item is accepted only in the idle state, so the table does
// not take the next item until the previous one has passed its commit step.
// A result waits in the output register while m_tready is low; the next
// item is still accepted and processed up to its commit step, which holds
// until the output register is free.
// Reset empties the set; the entry storage itself is not cleared.
module sorted_set_membership_table_core
#(
    parameter int DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ssmt_pkg::IN_TDATA_W-1:0]     s_tdata,  // [63:0] value
    input  logic [ssmt_pkg::FUNC_W-1:0]         s_tuser,  // [1:0] func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] was_member, [7:1] member_count, [8] add_dropped, [15:9] zero
    output logic [ssmt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    ssmt_pkg::ssmt_cmd_t              cmd;
    logic                             was_member;
    logic [ssmt_pkg::COUNT_W-1:0]     member_count;
    logic                             add_dropped;

    ssmt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ssmt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_func      (s_tuser),
        .in_value     (s_tdata[ssmt_pkg::VALUE_W-1:0]),
        .was_member   (was_member),
        .member_count (member_count),
        .add_dropped  (add_dropped)
    );

    // result packing
    assign m_tdata = {
        {(ssmt_pkg::OUT_TDATA_W - ssmt_pkg::COUNT_W - 2){1'b0}},
        add_dropped,
        member_count,
        was_member
    };

endmodule
